// ----- src/huffman_bit_packer_assert.svh -----
// Assertion macros for the bit packer; clocked on clk, disabled in rst.
`ifndef HUFFMAN_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_BIT_PACKER_ASSERT_SVH

// same-cycle implication
`define HBP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hbp_pkg.sv -----
package hbp_pkg;

  localparam int MAX_CODE_BITS = 16;
  localparam int SYMBOL_COUNT  = 256;

  localparam int BYTE_BITS = 8;
  localparam int WORD_BITS = 16;
  localparam int LEN_CAP   = (MAX_CODE_BITS < WORD_BITS) ? MAX_CODE_BITS : WORD_BITS;
  localparam int SYM_W     = 8;
  localparam int SYM_IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LEN_W     = 5;
  localparam int PEND_W    = 7;
  localparam int CNT_W     = 3;
  localparam int SUM_W     = 5;
  localparam int ACC_W     = PEND_W + WORD_BITS;
  localparam int ENTRY_W   = WORD_BITS + LEN_W;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]           op;
    logic [SYM_W-1:0]     symbol;
    logic [WORD_BITS-1:0] code_word;
    logic [LEN_W-1:0]     code_length;
  } sym_req_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;
  } byte_req_t;

endpackage

// ----- src/hbp_ram.sv -----
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/huffman_bit_packer.sv -----
// Huffman bit packer. Takes one request per cycle while sym_stall is low:
// table writes store a symbol's code and length in a 256-entry RAM (a flag
// per entry, cleared by reset, makes unloaded symbols zero length, so no
// clearing pass is needed), encodes append the symbol's code MSB-first and
// emit each full byte, and a flush emits the partial byte zero-padded at the
// bottom. A request is looked up in the cycle after acceptance and its bytes
// are loaded into the output register when the lookup stage advances. The
// output register drains one byte per cycle while byte_stall is low. A
// request yielding bytes stalls the input until the output register is free.
`include "huffman_bit_packer_assert.svh"

module huffman_bit_packer import hbp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      sym_valid,
  output logic      sym_stall,
  input  sym_req_t  sym_req,
  output logic      byte_valid,
  input  logic      byte_stall,
  output byte_req_t byte_req
);

  logic sym_acc;
  logic byte_acc;
  logic in_range;
  logic [SYM_IDX_W-1:0] idx;
  logic [LEN_W-1:0] len_sat;
  logic [WORD_BITS:0] mask_w;
  logic wr_en;
  logic rd_en;
  logic [ENTRY_W-1:0] wr_entry;
  logic [ENTRY_W-1:0] rd_entry;
  logic [SYMBOL_COUNT-1:0] len_valid;

  logic a_valid;
  logic [1:0] a_op;
  logic a_hit;
  logic a_adv;

  logic [PEND_W-1:0] pend_bits;
  logic [PEND_W-1:0] pend_bits_next;
  logic [CNT_W-1:0] pend_cnt;
  logic [CNT_W-1:0] pend_cnt_next;

  logic [WORD_BITS-1:0] e_code;
  logic [LEN_W-1:0] e_len;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_lo;
  logic [ACC_W-1:0] acc_hi;
  logic [SUM_W-1:0] cnt_sum;
  logic [CNT_W-1:0] rem;
  logic [PEND_W:0] rem_mask;
  logic [BYTE_BITS-1:0] flush_byte;
  logic [1:0] n_bytes;
  logic [BYTE_BITS-1:0] g_b0;
  logic [BYTE_BITS-1:0] g_b1;

  logic [1:0] ob_cnt;
  logic [1:0] ob_cnt_next;
  logic [BYTE_BITS-1:0] ob_b0;
  logic [BYTE_BITS-1:0] ob_b1;
  logic ob_free;

  assign sym_acc  = sym_valid && !sym_stall;
  assign byte_acc = byte_valid && !byte_stall;

  // table write / lookup issue
  assign in_range = {1'b0, sym_req.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign idx      = sym_req.symbol[SYM_IDX_W-1:0];
  assign len_sat  = (sym_req.code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP)
                                                            : sym_req.code_length;
  assign mask_w   = ((WORD_BITS + 1)'(1) << len_sat) - (WORD_BITS + 1)'(1);
  assign wr_entry = {sym_req.code_word & mask_w[WORD_BITS-1:0], len_sat};
  assign wr_en    = sym_acc && (sym_req.op == OP_WRITE) && in_range;
  assign rd_en    = sym_acc && (sym_req.op == OP_ENCODE);

  hbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      len_valid <= '0;
    end else if (wr_en) begin
      len_valid[idx] <= 1'b1;
    end
  end

  // lookup stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (sym_acc) begin
      a_valid <= (sym_req.op == OP_ENCODE) || (sym_req.op == OP_FLUSH);
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sym_acc) begin
      a_op  <= sym_req.op;
      a_hit <= in_range && len_valid[idx];
    end
  end

  // pack
  assign e_len    = a_hit ? rd_entry[LEN_W-1:0] : '0;
  assign e_code   = a_hit ? rd_entry[ENTRY_W-1:LEN_W] : '0;
  assign acc      = (ACC_W'(pend_bits) << e_len) | ACC_W'(e_code);
  assign cnt_sum  = SUM_W'(pend_cnt) + e_len;
  assign rem      = cnt_sum[CNT_W-1:0];
  assign acc_lo   = acc >> rem;
  assign acc_hi   = acc_lo >> BYTE_BITS;
  assign rem_mask = ((PEND_W + 1)'(1) << rem) - (PEND_W + 1)'(1);
  // pending << (8 - count)
  assign flush_byte = {pend_bits, 1'b0} << (~pend_cnt);

  always_comb begin
    n_bytes        = 2'd0;
    g_b0           = acc_lo[BYTE_BITS-1:0];
    g_b1           = acc_lo[BYTE_BITS-1:0];
    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    unique case (a_op)
      OP_ENCODE: begin
        n_bytes = 2'(cnt_sum >> CNT_W);
        if (n_bytes == 2'd2) begin
          g_b0 = acc_hi[BYTE_BITS-1:0];
        end
        pend_bits_next = acc[PEND_W-1:0] & rem_mask[PEND_W-1:0];
        pend_cnt_next  = rem;
      end
      OP_FLUSH: begin
        if (pend_cnt != '0) begin
          n_bytes = 2'd1;
          g_b0    = flush_byte;
        end
        pend_bits_next = '0;
        pend_cnt_next  = '0;
      end
      default: begin
      end
    endcase
  end

  assign ob_free   = (ob_cnt == 2'd0) || ((ob_cnt == 2'd1) && !byte_stall);
  assign a_adv     = a_valid && ((n_bytes == 2'd0) || ob_free);
  assign sym_stall = a_valid && !a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else if (a_adv) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

  // output buffer, up to two bytes of one request
  always_comb begin
    ob_cnt_next = ob_cnt;
    if (byte_acc) begin
      ob_cnt_next = ob_cnt - 2'd1;
    end
    if (a_adv && (n_bytes != 2'd0)) begin
      ob_cnt_next = n_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_cnt <= 2'd0;
    end else begin
      ob_cnt <= ob_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && (n_bytes != 2'd0)) begin
      ob_b0 <= g_b0;
      ob_b1 <= g_b1;
    end else if (byte_acc) begin
      ob_b0 <= ob_b1;
    end
  end

  assign byte_valid        = ob_cnt != 2'd0;
  assign byte_req.out_byte = ob_b0;
  assign byte_req.last     = ob_cnt == 2'd1;

  `HBP_ASSERT_IMPL(a_pend_clean, pend_cnt == '0, pend_bits == '0, "stale pending bits")
  `HBP_ASSERT_NEXT(a_group_load, a_adv && (n_bytes != 2'd0), ob_cnt == $past(n_bytes), "byte group lost")
  `HBP_ASSERT_NEXT(a_stage_load, sym_acc && (sym_req.op == OP_ENCODE || sym_req.op == OP_FLUSH), a_valid, "request dropped")

endmodule

// ----- verif/tb_huffman_bit_packer.sv -----
`timescale 1ns / 100ps

module tb_huffman_bit_packer;
  import hbp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TOTAL_ITEMS = 320;

  logic      clk;
  logic      rst = 1'b1;
  logic      sym_valid = 1'b0;
  logic      sym_stall;
  sym_req_t  sym_req = '0;
  logic      byte_valid;
  logic      byte_stall = 1'b0;
  byte_req_t byte_req;

  huffman_bit_packer u_top (
    .clk        (clk),
    .rst        (rst),
    .sym_valid  (sym_valid),
    .sym_stall  (sym_stall),
    .sym_req    (sym_req),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_req   (byte_req)
  );

  // predictor state
  logic [WORD_BITS-1:0] code_words [SYMBOL_COUNT];
  logic [LEN_W-1:0]     code_lens  [SYMBOL_COUNT];
  bit                   loaded     [SYMBOL_COUNT];
  logic [SYM_W-1:0]     loaded_syms [$];
  logic [PEND_W-1:0]    held_bits  = '0;
  logic [CNT_W-1:0]     held_count = '0;
  byte_req_t            packed_bytes_q [$];

  int errors      = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int stall_pct   = 0;
  int stall_left  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      code_words[i] = '0;
      code_lens[i]  = '0;
      loaded[i]     = 1'b0;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // bit-accurate packing of one accepted request
  task automatic pack_bits(input sym_req_t r);
    logic [LEN_W-1:0]     len;
    logic [WORD_BITS-1:0] word;
    logic [ACC_W-1:0]     acc;
    int                   cnt;
    int                   first;
    byte_req_t            b;
    case (r.op)
      OP_WRITE: begin
        if (int'(r.symbol) < SYMBOL_COUNT) begin
          len = r.code_length;
          if (len > LEN_CAP) len = LEN_W'(LEN_CAP);
          word = r.code_word;
          if (len < WORD_BITS) word &= (WORD_BITS'(1) << len) - WORD_BITS'(1);
          code_words[r.symbol] = word;
          code_lens[r.symbol]  = len;
          if (!loaded[r.symbol]) loaded_syms = {loaded_syms, r.symbol};
          loaded[r.symbol] = 1'b1;
        end
      end
      OP_ENCODE: begin
        len  = '0;
        word = '0;
        if (int'(r.symbol) < SYMBOL_COUNT) begin
          len  = code_lens[r.symbol];
          word = code_words[r.symbol];
        end
        acc   = (ACC_W'(held_bits) << len) | ACC_W'(word);
        cnt   = int'(held_count) + int'(len);
        first = packed_bytes_q.size();
        while (cnt >= BYTE_BITS) begin
          cnt -= BYTE_BITS;
          b.out_byte = BYTE_BITS'(acc >> cnt);
          b.last     = 1'b0;
          packed_bytes_q = {packed_bytes_q, b};
        end
        if (packed_bytes_q.size() > first)
          packed_bytes_q[packed_bytes_q.size()-1].last = 1'b1;
        held_bits  = PEND_W'(acc & ((ACC_W'(1) << cnt) - ACC_W'(1)));
        held_count = CNT_W'(cnt);
      end
      OP_FLUSH: begin
        if (held_count != 0) begin
          b.out_byte = BYTE_BITS'(16'(held_bits) << (BYTE_BITS - int'(held_count)));
          b.last     = 1'b1;
          packed_bytes_q = {packed_bytes_q, b};
        end
        held_bits  = '0;
        held_count = '0;
      end
      default: ;
    endcase
  endtask

  // valid stays high between back-to-back requests; bursts end in a gap
  task automatic send_item(input sym_req_t r);
    if (burst_left == 0) begin
      sym_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    sym_valid <= 1'b1;
    sym_req   <= r;
    do @(posedge clk); while (sym_stall);
    burst_left--;
    if (r.op != OP_UNUSED) items_sent++;
    pack_bits(r);
  endtask

  function automatic sym_req_t rand_req(input logic [1:0] op);
    sym_req_t r;
    r.op          = op;
    r.symbol      = SYM_W'($urandom);
    r.code_word   = WORD_BITS'($urandom);
    r.code_length = LEN_W'($urandom);
    return r;
  endfunction

  task automatic write_code(input logic [7:0] sym, input logic [15:0] word,
                            input logic [4:0] len);
    sym_req_t r;
    r = rand_req(OP_WRITE);
    r.symbol      = sym;
    r.code_word   = word;
    r.code_length = len;
    send_item(r);
  endtask

  task automatic encode_sym(input logic [7:0] sym);
    sym_req_t r;
    r = rand_req(OP_ENCODE);
    r.symbol = sym;
    send_item(r);
  endtask

  task automatic encode_loaded();
    encode_sym(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
  endtask

  // receiver: stall rate is redrawn for each stretch, including stall-free stretches
  always @(posedge clk) begin
    byte_req_t exp_b;
    if (!rst && byte_valid && !byte_stall) begin
      if (packed_bytes_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b",
                                  byte_req.out_byte, byte_req.last));
      end else begin
        exp_b = packed_bytes_q.pop_front();
        if (byte_req.out_byte !== exp_b.out_byte)
          report_mismatch($sformatf("out_byte %02h, want %02h",
                                    byte_req.out_byte, exp_b.out_byte));
        if (byte_req.last !== exp_b.last)
          report_mismatch($sformatf("last %0b, want %0b on byte %02h",
                                    byte_req.last, exp_b.last, exp_b.out_byte));
      end
    end
    if (stall_left == 0) begin
      stall_left = $urandom_range(8, 64);
      case ($urandom_range(3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    stall_left--;
    byte_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic test_idle_ops();
    send_item(rand_req(OP_FLUSH));
    send_item(rand_req(OP_UNUSED));
  endtask

  task automatic test_table_writes();
    write_code(8'h00, 16'hFFFF, 5'd16);
    write_code(8'hFF, 16'hFFFF, 5'd31);
    write_code(8'h5A, 16'hFFFF, 5'd3);
    write_code(8'hA5, 16'h1234, 5'd0);
    write_code(8'h01, 16'h0000, 5'd1);
    write_code(8'h80, 16'hFF55, 5'd7);
    write_code(8'h3C, 16'hA5C3, 5'd17);
  endtask

  task automatic test_encode_directed();
    encode_sym(8'hA5);
    encode_sym(8'h5A);
    encode_sym(8'h80);
    encode_sym(8'h00);
    encode_sym(8'hFF);
    encode_sym(8'h3C);
    encode_sym(8'h01);
  endtask

  task automatic test_flush_directed();
    send_item(rand_req(OP_FLUSH));
    send_item(rand_req(OP_FLUSH));
    encode_sym(8'h80);
    send_item(rand_req(OP_FLUSH));
  endtask

  // code-table loads, then mostly encode runs, most of them ending in a flush
  task automatic test_random_stream();
    sym_req_t r;
    repeat (24) begin
      r = rand_req(OP_WRITE);
      r.code_length = LEN_W'($urandom_range(1, 16));
      send_item(r);
    end
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(9))
        0: repeat ($urandom_range(1, 4)) send_item(rand_req(OP_WRITE));
        1: begin
          if ($urandom_range(1)) send_item(rand_req(OP_UNUSED));
          else send_item(rand_req(OP_FLUSH));
        end
        default: begin
          repeat ($urandom_range(1, 24)) encode_loaded();
          if ($urandom_range(3) != 0) send_item(rand_req(OP_FLUSH));
        end
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_idle_ops();
    test_table_writes();
    test_encode_directed();
    test_flush_directed();
    test_random_stream();
    sym_valid <= 1'b0;
    while (packed_bytes_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
